/* rtl/mobius_mertens_accumulator_top_defines.svh */
// Assertion macros shared by the checker of the accumulator top level.
`ifndef MOBIUS_MERTENS_ACCUMULATOR_TOP_DEFINES_SVH
`define MOBIUS_MERTENS_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mma_pkg.sv */
package mma_pkg;

    localparam int NUM_BITS = 32;
    localparam int NUMBER_W = 32;
    localparam int MU_W     = 2;
    localparam int SUM_W    = 32;
    localparam int HITS_W   = 32;

    // Trial divisors never pass sqrt(2^NUM_BITS) plus one step of four.
    localparam int D_W   = NUM_BITS / 2 + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    localparam logic signed [MU_W-1:0] MU_POS  = 2'sb01;
    localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
    localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [HITS_W-1:0]       HITS_MAX = {HITS_W{1'b1}};

    typedef struct packed {
        logic load;
        logic start_div;
        logic take_quot;
        logic advance;
        logic mark_square;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic num_zero;
        logic sq_le_rest;
        logic div_done;
        logic rem_zero;
        logic seen_once;
        logic out_free;
    } t_stat;

endpackage

/* rtl/mma_in_if.sv */
interface mma_in_if
    import mma_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

/* rtl/mma_out_if.sv */
interface mma_out_if
    import mma_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [MU_W-1:0]   mobius_value;
    logic signed [SUM_W-1:0]  mertens_sum;
    logic [HITS_W-1:0]        zero_hits;

    modport source (output valid, output mobius_value, output mertens_sum,
                    output zero_hits, input ready);
    modport sink (input valid, input mobius_value, input mertens_sum,
                  input zero_hits, output ready);
endinterface

/* rtl/mma_div.sv */
module mma_div
    import mma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [D_W-1:0]      i_divisor,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot,
    output logic [D_W-1:0]      o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_BITS-1:0] r_q, n_q;
    logic [D_W-1:0]    r_rem, n_rem;
    logic [D_W-1:0]    r_dv, n_dv;
    logic [D_W:0]      trial;
    logic              ge;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign trial = {r_rem, r_q[NUM_BITS-1]};
    assign ge    = trial >= {1'b0, r_dv};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dv   = r_dv;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_BITS);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dv   = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[NUM_BITS-2:0], ge};
            n_rem = ge ? D_W'(trial - {1'b0, r_dv}) : D_W'(trial);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dv  <= n_dv;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

/* rtl/mma_datapath.sv */
module mma_datapath
    import mma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [NUMBER_W-1:0]      i_number,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [MU_W-1:0]   o_mobius_value,
    output logic signed [SUM_W-1:0]  o_mertens_sum,
    output logic [HITS_W-1:0]        o_zero_hits
);

    logic [NUM_BITS-1:0] r_rest, n_rest;
    logic [D_W-1:0]      r_d, n_d;
    logic [SQ_W-1:0]     r_sq;
    logic                r_step_two, n_step_two;
    logic                r_seen, n_seen;
    logic                r_par, n_par;
    logic                r_square, n_square;

    logic                     r_out_valid, n_out_valid;
    logic signed [MU_W-1:0]   r_mu_out, n_mu_out;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [HITS_W-1:0]        r_hits, n_hits;
    logic signed [SUM_W-1:0]  r_sum_out, n_sum_out;
    logic [HITS_W-1:0]        r_hits_out, n_hits_out;

    logic                     div_done;
    logic [NUM_BITS-1:0]      div_quot;
    logic [D_W-1:0]           div_rem;
    logic signed [MU_W-1:0]   mu;
    logic [SQ_W-1:0]          d_sq;

    mma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (r_rest),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // The full-width target widens both operands before the multiply.
    assign d_sq = r_d * r_d;

    // Whatever is left above one after all trial divisors is one more prime.
    always_comb begin
        if (r_square) begin
            mu = MU_ZERO;
        end else if (r_par ^ (r_rest != NUM_BITS'(1))) begin
            mu = MU_NEG;
        end else begin
            mu = MU_POS;
        end
    end

    always_comb begin
        n_rest     = r_rest;
        n_d        = r_d;
        n_step_two = r_step_two;
        n_seen     = r_seen;
        n_par      = r_par;
        n_square   = r_square;
        if (i_cmd.load) begin
            n_rest     = i_number[NUM_BITS-1:0];
            n_d        = D_W'(2);
            n_step_two = 1'b0;
            n_seen     = 1'b0;
            n_par      = 1'b0;
            n_square   = 1'b0;
        end
        if (i_cmd.take_quot) begin
            n_rest = div_quot;
            n_seen = 1'b1;
            n_par  = ~r_par;
        end
        if (i_cmd.mark_square) begin
            n_square = 1'b1;
        end
        if (i_cmd.advance) begin
            n_seen = 1'b0;
            // Divisors 2, 3, 5, then +2 and +4 in turn over 6k-1 and 6k+1.
            if (r_d == D_W'(2)) begin
                n_d = D_W'(3);
            end else if (r_d == D_W'(3)) begin
                n_d        = D_W'(5);
                n_step_two = 1'b1;
            end else begin
                n_d        = r_step_two ? r_d + D_W'(2) : r_d + D_W'(4);
                n_step_two = ~r_step_two;
            end
        end
    end

    always_comb begin
        n_sum       = r_sum;
        n_hits      = r_hits;
        n_out_valid = r_out_valid;
        n_mu_out    = r_mu_out;
        n_sum_out   = r_sum_out;
        n_hits_out  = r_hits_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.finish) begin
            if (mu == MU_POS && r_sum != SUM_MAX) begin
                n_sum = r_sum + SUM_W'(1);
            end else if (mu == MU_NEG && r_sum != SUM_MIN) begin
                n_sum = r_sum - SUM_W'(1);
            end
            if (n_sum == '0 && r_hits != HITS_MAX) begin
                n_hits = r_hits + HITS_W'(1);
            end
            n_out_valid = 1'b1;
            n_mu_out    = mu;
            n_sum_out   = n_sum;
            n_hits_out  = n_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_hits      <= n_hits;
            r_out_valid <= n_out_valid;
        end
        r_rest     <= n_rest;
        r_d        <= n_d;
        r_sq       <= d_sq;
        r_step_two <= n_step_two;
        r_seen     <= n_seen;
        r_par      <= n_par;
        r_square   <= n_square;
        r_mu_out   <= n_mu_out;
        r_sum_out  <= n_sum_out;
        r_hits_out <= n_hits_out;
    end

    assign o_stat.num_zero   = r_rest == '0;
    assign o_stat.sq_le_rest = r_sq <= SQ_W'(r_rest);
    assign o_stat.div_done   = div_done;
    assign o_stat.rem_zero   = div_rem == '0;
    assign o_stat.seen_once  = r_seen;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_mobius_value = r_mu_out;
    assign o_mertens_sum  = r_sum_out;
    assign o_zero_hits    = r_hits_out;

endmodule

/* rtl/mma_ctrl.sv */
module mma_ctrl
    import mma_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RE   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ;
                end
            end
            // The square of the new divisor is registered here.
            S_SQ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_stat.num_zero) begin
                    o_cmd.mark_square = 1'b1;
                    n_state           = S_FIN;
                end else if (i_stat.sq_le_rest) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    priority if (!i_stat.rem_zero) begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_SQ;
                    end else if (i_stat.seen_once) begin
                        o_cmd.mark_square = 1'b1;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.take_quot = 1'b1;
                        n_state         = S_RE;
                    end
                end
            end
            // Divide the quotient by the same prime once more.
            S_RE: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/mobius_mertens_accumulator_top.sv */
// Mobius value and Mertens sum of a stream of integers.
// i_in carries one request per integer (number); o_out returns one result per
// request: the Mobius value, the running Mertens sum after it and the count of
// results so far at which that sum was zero. Both the sum and the count saturate.
// An item is taken only while the block is idle. Its factoring runs trial
// division with a shared restoring divider that makes one quotient bit a
// cycle. Each candidate divisor costs a division plus the squared-divisor
// check. The work for a number n grows with sqrt(n) in the worst case and
// shrinks when small factors are divided out; one and zero need no division.
// The result lands in an output register, and the block is ready for the
// next request while that result waits. If the receiver stalls, a finished
// item waits in the last control state until the output register frees.
// Reset clears the running sum, the zero count and the output valid flag.
module mobius_mertens_accumulator_top
    import mma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    mma_in_if.sink   i_in,
    mma_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    mma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mma_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_number       (i_in.number),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_mobius_value (o_out.mobius_value),
        .o_mertens_sum  (o_out.mertens_sum),
        .o_zero_hits    (o_out.zero_hits)
    );

endmodule

/* rtl/mma_checker.sv */
`include "mobius_mertens_accumulator_top_defines.svh"

module mma_checker
    import mma_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [MU_W-1:0]   i_mobius_value,
    input logic signed [SUM_W-1:0]  i_mertens_sum,
    input logic [HITS_W-1:0]        i_zero_hits
);

    // A Mobius value is never the unused code two.
    `MMA_ASSERT_NOW(a_mu_code, i_clk, i_rst_n, i_out_valid, i_mobius_value != 2'sb10, "mobius_value carries an invalid code")

    // A zero sum has always been counted at least once.
    `MMA_ASSERT_NOW(a_zero_counted, i_clk, i_rst_n, i_out_valid && i_mertens_sum == '0, i_zero_hits != '0, "zero sum shown with no zero hit counted")

    // A taken request moves the controller out of idle, so ready drops.
    `MMA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready stayed high after a request was taken")

    // A stalled result holds.
    `MMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mertens_sum) && $stable(i_zero_hits) && $stable(i_mobius_value), "stalled result changed")

endmodule

bind mobius_mertens_accumulator_top mma_checker u_mma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_mobius_value (o_out.mobius_value),
    .i_mertens_sum  (o_out.mertens_sum),
    .i_zero_hits    (o_out.zero_hits)
);

/* sim/mobius_mertens_accumulator_top_test.sv */
module mobius_mertens_accumulator_top_test
    import mma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 78;
    localparam logic [NUMBER_W-1:0] NUMBER_MASK = {NUMBER_W{1'b1}} >> (NUMBER_W - NUM_BITS);

    typedef struct {
        logic signed [MU_W-1:0]  mu;
        logic signed [SUM_W-1:0] sum;
        logic [HITS_W-1:0]       hits;
    } t_mertens_result;

    logic i_clk;
    logic i_rst_n;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();

    mobius_mertens_accumulator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [NUMBER_W-1:0]     pending_numbers[$];
    t_mertens_result         expected_results[$];
    logic signed [SUM_W-1:0] mertens_total;
    logic [HITS_W-1:0]       zero_sum_count;
    int unsigned             accepted_numbers;
    int unsigned             mismatch_count;
    int unsigned             src_idle_pct;
    int unsigned             sink_idle_pct;
    int unsigned             quiet_cycles;

    wire in_fire  = in_ch.valid && in_ch.ready;
    wire out_fire = out_ch.valid && out_ch.ready;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // Trial division over 2, 3 and then the 6k-1 / 6k+1 candidates.
    function automatic logic signed [MU_W-1:0] mobius_by_trial_division(
        logic [NUMBER_W-1:0] raw
    );
        longint unsigned     rest;
        longint unsigned     divisor;
        int unsigned         prime_count;
        int unsigned         times;
        logic [NUMBER_W-1:0] n;
        n = raw & NUMBER_MASK;
        if (n == '0) begin
            return MU_ZERO;
        end
        rest = n;
        divisor = 2;
        prime_count = 0;
        while (divisor * divisor <= rest) begin
            times = 0;
            while (rest % divisor == 0) begin
                rest = rest / divisor;
                times++;
                if (times > 1) begin
                    return MU_ZERO;
                end
            end
            prime_count += times;
            if (divisor == 2) begin
                divisor = 3;
            end else if (divisor == 3) begin
                divisor = 5;
            end else if (divisor % 6 == 5) begin
                divisor += 2;
            end else begin
                divisor += 4;
            end
        end
        if (rest != 1) begin
            prime_count++;
        end
        return prime_count[0] ? MU_NEG : MU_POS;
    endfunction

    task automatic predict_mertens_step(logic [NUMBER_W-1:0] number);
        longint          next_total;
        t_mertens_result res;
        res.mu = mobius_by_trial_division(number);
        next_total = longint'(mertens_total) + longint'(res.mu);
        if (next_total > longint'(SUM_MAX)) begin
            next_total = longint'(SUM_MAX);
        end
        if (next_total < longint'(SUM_MIN)) begin
            next_total = longint'(SUM_MIN);
        end
        mertens_total = next_total[SUM_W-1:0];
        if (mertens_total == 0 && zero_sum_count != HITS_MAX) begin
            zero_sum_count++;
        end
        res.sum = mertens_total;
        res.hits = zero_sum_count;
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Driver: predictions are made at the edge where a request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                predict_mertens_step(in_ch.number);
                accepted_numbers++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.number <= pending_numbers.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_mertens_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result mu=%0d sum=%0d hits=%0d",
                        out_ch.mobius_value, out_ch.mertens_sum, out_ch.zero_hits));
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.mobius_value !== want.mu) begin
                        report_mismatch($sformatf("mobius_value got %0d, expected %0d",
                            out_ch.mobius_value, want.mu));
                    end
                    if (out_ch.mertens_sum !== want.sum) begin
                        report_mismatch($sformatf("mertens_sum got %0d, expected %0d",
                            out_ch.mertens_sum, want.sum));
                    end
                    if (out_ch.zero_hits !== want.hits) begin
                        report_mismatch($sformatf("zero_hits got %0d, expected %0d",
                            out_ch.zero_hits, want.hits));
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int unsigned total_items;
        int unsigned next_number;
        int unsigned pick;
        int unsigned factor_lo;
        int unsigned factor_hi;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.number = '0;
        out_ch.ready = 1'b0;
        mertens_total = '0;
        zero_sum_count = '0;
        accepted_numbers = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        src_idle_pct = 10;
        sink_idle_pct = 80;

        // The normal sequence from one, which covers primes, squares and products.
        for (next_number = 1; next_number <= 12; next_number++) begin
            pending_numbers.push_back(next_number);
        end
        // Zero, squares of 6k-1 and 6k+1 primes, and values at the top of the range.
        pending_numbers.push_back(32'd0);
        pending_numbers.push_back(32'd25);
        pending_numbers.push_back(32'd30);
        pending_numbers.push_back(32'd35);
        pending_numbers.push_back(32'd49);
        pending_numbers.push_back(32'd1);
        pending_numbers.push_back(32'hFFFF_FFFF);
        pending_numbers.push_back(32'h8000_0000);
        pending_numbers.push_back(32'hFFFF_FFFC);
        pending_numbers.push_back(32'h7FFF_FFFE);

        // Mostly the running sequence, with jumps, small noise, and large values
        // built from two factors so that trial division stays short.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                if (pick < 4) begin
                    next_number += $urandom_range(40, 1);
                end
                pending_numbers.push_back(next_number);
                next_number++;
            end else if (pick < 86) begin
                pending_numbers.push_back($urandom_range(65535, 0));
            end else begin
                factor_lo = $urandom_range(1023, 1);
                factor_hi = $urandom_range(32'h003F_FFFF, 1);
                pending_numbers.push_back(factor_lo * factor_hi);
            end
        end
        total_items = pending_numbers.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_numbers < total_items / 3) @(posedge i_clk);
        src_idle_pct = 80;
        sink_idle_pct = 10;
        while (accepted_numbers < 2 * total_items / 3) @(posedge i_clk);
        src_idle_pct = 0;
        sink_idle_pct = 0;

        while (pending_numbers.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
